### rtl/imm_pkg.sv
// Shared types and constants for the int8 matrix multiply engine.
package imm_pkg;

    localparam int COLS_MAX_DEF  = 16;
    localparam int DEPTH_MAX_DEF = 256;

    localparam int VAL_W  = 8;
    localparam int PROD_W = 16;
    localparam int SUM_W  = 24;
    localparam int ROW_W  = 16;
    localparam int COL_W  = 4;
    localparam int OUT_DW = 48;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam int M_W = 16;
    localparam int K_W = 9;
    localparam int N_W = 5;

    localparam logic [M_W-1:0] M_ROWS_RST  = 16'd1;
    localparam logic [K_W-1:0] K_DEPTH_RST = 9'd256;
    localparam logic [N_W-1:0] N_COLS_RST  = 5'd16;

    localparam logic [1:0] REG_M_ROWS  = 2'd0;
    localparam logic [1:0] REG_K_DEPTH = 2'd1;
    localparam logic [1:0] REG_N_COLS  = 2'd2;

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_ACT    = 1'b1;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

### rtl/imm_cell.sv
// One column-sum cell of the rotating accumulator chain.
module imm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  imm_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_is_tail,
    input  logic                        i_live,
    input  logic [imm_pkg::SUM_W-1:0]   i_next,
    input  logic [imm_pkg::SUM_W-1:0]   i_fb,
    output logic [imm_pkg::SUM_W-1:0]   o_sum
);

    logic [imm_pkg::SUM_W-1:0] r_sum;
    logic [imm_pkg::SUM_W-1:0] n_sum;

    always_comb begin
        n_sum = r_sum;
        if (i_ctl.clear) begin
            n_sum = '0;
        end else if (i_ctl.shift && i_live) begin
            // tail closes the ring through the head update path
            n_sum = i_is_tail ? i_fb : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

### rtl/imm_ctrl.sv
// Sequencer: weight store, multiplier, row/column counters and result register.
module imm_ctrl #(
    parameter int COLS_MAX  = imm_pkg::COLS_MAX_DEF,
    parameter int DEPTH_MAX = imm_pkg::DEPTH_MAX_DEF,
    localparam int KW = $clog2(DEPTH_MAX + 1),
    localparam int CW = $clog2(COLS_MAX + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [imm_pkg::VAL_W-1:0]    i_s_tdata,
    input  logic                         i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [imm_pkg::OUT_DW-1:0]   o_m_tdata,
    output logic                         o_m_tlast,
    output logic                         o_m_tuser,
    input  logic [imm_pkg::M_W-1:0]      i_m_rows,
    input  logic [KW-1:0]                i_k_eff,
    input  logic [CW-1:0]                i_n_eff,
    input  logic [imm_pkg::SUM_W-1:0]    i_head_sum,
    output imm_pkg::t_cell_ctl           o_ctl,
    output logic [imm_pkg::SUM_W-1:0]    o_fb
);

    localparam int S  = COLS_MAX * DEPTH_MAX;
    localparam int AW = (S > 1) ? $clog2(S) : 1;
    localparam int LW = AW + 1;
    localparam int PW = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX) : 1;
    localparam int JW = (CW < imm_pkg::COL_W) ? imm_pkg::COL_W : CW;
    localparam int RW = imm_pkg::ROW_W;
    localparam int PAD_W = imm_pkg::OUT_DW - imm_pkg::SUM_W - imm_pkg::COL_W - RW;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ACC  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic signed [imm_pkg::VAL_W-1:0]  r_mem [S];
    logic signed [imm_pkg::VAL_W-1:0]  r_v;
    logic signed [imm_pkg::VAL_W-1:0]  r_rd_data;
    logic signed [imm_pkg::PROD_W-1:0] r_prod;
    logic [AW-1:0]                     r_addr;
    logic [AW-1:0]                     r_ptr;
    logic [PW-1:0]                     r_pos;
    logic [RW-1:0]                     r_row;
    logic [JW-1:0]                     r_col;
    logic [CW-1:0]                     r_issue_cnt;
    logic                              r_rd_vld;
    logic                              r_mul_vld;

    logic                              r_out_vld;
    logic [RW-1:0]                     r_o_row;
    logic [imm_pkg::COL_W-1:0]         r_o_col;
    logic [imm_pkg::SUM_W-1:0]         r_o_sum;
    logic                              r_o_lr;
    logic                              r_o_lm;

    logic          w_in_acc, w_wt, w_act, w_rd_en, w_acc_done, w_row_end;
    logic          w_load, w_col_last, w_last_row;
    logic [LW-1:0] w_limit, w_wnext, w_step;
    logic [AW-1:0] w_waddr, w_addr_nx;

    assign w_in_acc   = i_s_tvalid && (r_state == S_IDLE);
    assign w_wt       = w_in_acc && (i_s_tuser == imm_pkg::OP_WEIGHT);
    assign w_act      = w_in_acc && (i_s_tuser == imm_pkg::OP_ACT);
    assign w_rd_en    = (r_state == S_ACC) && (r_issue_cnt < i_n_eff);
    assign w_acc_done = (r_state == S_ACC) && (r_issue_cnt == i_n_eff)
                        && !r_rd_vld && !r_mul_vld;
    assign w_row_end  = (KW'(r_pos) + KW'(1)) >= i_k_eff;
    assign w_load     = (r_state == S_EMIT) && (!r_out_vld || i_m_tready);
    assign w_col_last = (r_col + JW'(1)) == JW'(i_n_eff);
    assign w_last_row = ({1'b0, r_row} + (RW+1)'(1)) >= {1'b0, i_m_rows};

    // weight write pointer, wraps over n_cols * k_depth
    assign w_limit = LW'(i_n_eff) * LW'(i_k_eff);
    assign w_waddr = (LW'(r_ptr) < w_limit) ? r_ptr : '0;
    assign w_wnext = LW'(w_waddr) + LW'(1);

    // column j reads entry (j*k + pos) mod S; step by k with one fold
    assign w_step    = LW'(r_addr) + LW'(i_k_eff);
    assign w_addr_nx = (w_step >= LW'(S)) ? AW'(w_step - LW'(S)) : AW'(w_step);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_act) n_state = S_ACC;
            S_ACC:  if (w_acc_done) n_state = w_row_end ? S_EMIT : S_IDLE;
            S_EMIT: if (w_load && w_col_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_pos       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_issue_cnt <= '0;
            r_rd_vld    <= 1'b0;
            r_mul_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= w_rd_en;
            r_mul_vld <= r_rd_vld;
            if (w_wt) begin
                r_ptr <= (w_wnext >= w_limit) ? '0 : AW'(w_wnext);
                r_pos <= '0;
            end
            if (w_act) begin
                r_issue_cnt <= '0;
            end else if (w_rd_en) begin
                r_issue_cnt <= r_issue_cnt + CW'(1);
            end
            if (w_acc_done) begin
                if (w_row_end) begin
                    r_pos <= '0;
                    r_col <= '0;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
            if (w_load) begin
                if (w_col_last) begin
                    r_row <= w_last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + JW'(1);
                end
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wt) begin
            r_mem[w_waddr] <= i_s_tdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
        if (w_act) begin
            r_v    <= i_s_tdata;
            r_addr <= AW'(r_pos);
        end else if (w_rd_en) begin
            r_addr <= w_addr_nx;
        end
        r_prod <= r_v * r_rd_data;
        if (w_load) begin
            r_o_row <= r_row;
            r_o_col <= r_col[imm_pkg::COL_W-1:0];
            r_o_sum <= i_head_sum;
            r_o_lr  <= w_col_last;
            r_o_lm  <= w_col_last && w_last_row;
        end
    end

    // ring: rotate per product and per emitted column but the last
    assign o_ctl.clear = w_wt || (w_load && w_col_last);
    assign o_ctl.shift = r_mul_vld || (w_load && !w_col_last);
    assign o_fb = r_mul_vld
                  ? i_head_sum + {{(imm_pkg::SUM_W-imm_pkg::PROD_W){r_prod[imm_pkg::PROD_W-1]}},
                                  r_prod}
                  : '0;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_o_sum, r_o_col, r_o_row};
    assign o_m_tlast  = r_o_lr;
    assign o_m_tuser  = r_o_lm;

`ifndef SYNTH
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_issue_cnt <= i_n_eff))
        else $error("read issue count past column count");
    a_mul_in_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld || r_mul_vld) |-> (r_state == S_ACC))
        else $error("multiply pipeline busy outside accumulate");
    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_col_last) |=> (r_state == S_IDLE) && r_out_vld && r_o_lr)
        else $error("last column did not close the row");
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wt |=> (LW'(r_ptr) < w_limit))
        else $error("weight pointer outside store range");
`endif

endmodule

### rtl/int8_matmul_engine.sv
// Top level: APB registers, column-sum cell chain and sequencer.
//
// Signed int8 matrix multiply C = A * B^T with exact 24-bit sums.
// Input stream: tuser = opcode (0 weight, 1 activation), tdata = value.
// Weight beats fill the store of n_cols rows by k_depth elements in
// row-major order; each also clears the partial sums and the row position.
// Activation beats stream A row by row. After the last element of a row the
// block sends n_cols result beats, column 0 first; tlast marks the last
// column of the row, tuser marks the last column of the last row of a matrix.
// Each activation beat passes through the single store read port feeding
// one multiplier, with a rotating chain of column-sum cells taking one
// product per cycle; no new beat is taken until it is done. Row end adds n_cols result
// beats, one per cycle while the receiver takes them; a stalled receiver
// holds the result register and the sequencer until it drains.
// Reset (synchronous, active low) clears sums, counters and registers to
// m_rows 1, k_depth 256, n_cols 16; the weight store is not cleared.
// Registers (APB, byte address 4*i): m_rows, k_depth, n_cols.
module int8_matmul_engine #(
    parameter int COLS_MAX  = imm_pkg::COLS_MAX_DEF,
    parameter int DEPTH_MAX = imm_pkg::DEPTH_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [imm_pkg::VAL_W-1:0]    i_s_axis_tdata,   // [7:0] value
    input  logic                         i_s_axis_tuser,   // [0] opcode
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [15:0] row_index, [19:16] col_index, [43:20] sum, [47:44] zero
    output logic [imm_pkg::OUT_DW-1:0]   o_m_axis_tdata,
    output logic                         o_m_axis_tlast,   // last_of_row
    output logic                         o_m_axis_tuser,   // [0] last_of_matrix
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [imm_pkg::APB_AW-1:0]   paddr,
    input  logic [imm_pkg::APB_DW-1:0]   pwdata,
    output logic [imm_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int KW = $clog2(DEPTH_MAX + 1);
    localparam int CW = $clog2(COLS_MAX + 1);
    localparam int TW = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
    localparam int SW = imm_pkg::SUM_W;

    logic [imm_pkg::M_W-1:0] r_m_rows;
    logic [imm_pkg::K_W-1:0] r_k_depth;
    logic [imm_pkg::N_W-1:0] r_n_cols;

    logic [imm_pkg::M_W-1:0] w_m_eff;
    logic [KW-1:0]           w_k_eff;
    logic [CW-1:0]           w_n_eff;
    logic [TW-1:0]           w_tail;
    logic                    w_wr;

    imm_pkg::t_cell_ctl      w_ctl;
    logic [SW-1:0]           w_fb;
    logic [SW-1:0]           w_sum [COLS_MAX];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_rows  <= imm_pkg::M_ROWS_RST;
            r_k_depth <= imm_pkg::K_DEPTH_RST;
            r_n_cols  <= imm_pkg::N_COLS_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                imm_pkg::REG_M_ROWS:  r_m_rows  <= pwdata[imm_pkg::M_W-1:0];
                imm_pkg::REG_K_DEPTH: r_k_depth <= pwdata[imm_pkg::K_W-1:0];
                imm_pkg::REG_N_COLS:  r_n_cols  <= pwdata[imm_pkg::N_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            imm_pkg::REG_M_ROWS:  prdata = imm_pkg::APB_DW'(r_m_rows);
            imm_pkg::REG_K_DEPTH: prdata = imm_pkg::APB_DW'(r_k_depth);
            imm_pkg::REG_N_COLS:  prdata = imm_pkg::APB_DW'(r_n_cols);
            default:              prdata = '0;
        endcase
    end

    // zero acts as one; oversize clamps to the built size
    always_comb begin
        w_m_eff = (r_m_rows == '0) ? imm_pkg::M_W'(1) : r_m_rows;
        if (r_k_depth == '0) begin
            w_k_eff = KW'(1);
        end else if (int'(r_k_depth) > DEPTH_MAX) begin
            w_k_eff = KW'(DEPTH_MAX);
        end else begin
            w_k_eff = KW'(r_k_depth);
        end
        if (r_n_cols == '0) begin
            w_n_eff = CW'(1);
        end else if (int'(r_n_cols) > COLS_MAX) begin
            w_n_eff = CW'(COLS_MAX);
        end else begin
            w_n_eff = CW'(r_n_cols);
        end
    end

    assign w_tail = TW'(w_n_eff - CW'(1));

    for (genvar i = 0; i < COLS_MAX; i++) begin : g_cell
        logic [SW-1:0] w_next;
        if (i == COLS_MAX - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_sum[i+1];
        end
        imm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_is_tail (TW'(i) == w_tail),
            .i_live    (TW'(i) <= w_tail),
            .i_next    (w_next),
            .i_fb      (w_fb),
            .o_sum     (w_sum[i])
        );
    end

    imm_ctrl #(
        .COLS_MAX  (COLS_MAX),
        .DEPTH_MAX (DEPTH_MAX)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast),
        .o_m_tuser  (o_m_axis_tuser),
        .i_m_rows   (w_m_eff),
        .i_k_eff    (w_k_eff),
        .i_n_eff    (w_n_eff),
        .i_head_sum (w_sum[0]),
        .o_ctl      (w_ctl),
        .o_fb       (w_fb)
    );

endmodule

### test/tb_int8_matmul_engine.sv
// Self-checking testbench for int8_matmul_engine: stream stimulus, APB setup and result check.

localparam int STORE_SZ = imm_pkg::COLS_MAX_DEF * imm_pkg::DEPTH_MAX_DEF;

typedef struct packed {
    logic [imm_pkg::ROW_W-1:0] row;
    logic [imm_pkg::COL_W-1:0] col;
    logic [imm_pkg::SUM_W-1:0] sum;
    logic                      row_end;
    logic                      matrix_end;
} t_sum_beat;

class column_sum_tracker;
    bit [imm_pkg::M_W-1:0]   m_rows  = imm_pkg::M_ROWS_RST;
    bit [imm_pkg::K_W-1:0]   k_depth = imm_pkg::K_DEPTH_RST;
    bit [imm_pkg::N_W-1:0]   n_cols  = imm_pkg::N_COLS_RST;
    bit [imm_pkg::VAL_W-1:0] weights [STORE_SZ];
    bit                      loaded  [STORE_SZ];
    bit [imm_pkg::SUM_W-1:0] acc     [imm_pkg::COLS_MAX_DEF];
    int unsigned             w_ptr;
    int unsigned             k_pos;
    int unsigned             row_cnt;
    t_sum_beat               pending [$];
    int                      errors;
    int                      beats_seen;

    function int unsigned rows_eff();
        return (m_rows == 0) ? 1 : m_rows;
    endfunction

    function int unsigned depth_eff();
        if (k_depth == 0) return 1;
        return (k_depth > imm_pkg::DEPTH_MAX_DEF) ? imm_pkg::DEPTH_MAX_DEF : k_depth;
    endfunction

    function int unsigned cols_eff();
        if (n_cols == 0) return 1;
        return (n_cols > imm_pkg::COLS_MAX_DEF) ? imm_pkg::COLS_MAX_DEF : n_cols;
    endfunction

    function void note_mismatch(string what);
        errors++;
        if (errors <= 10) $display("MISMATCH: %s", what);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            imm_pkg::REG_M_ROWS:  m_rows  = val[imm_pkg::M_W-1:0];
            imm_pkg::REG_K_DEPTH: k_depth = val[imm_pkg::K_W-1:0];
            imm_pkg::REG_N_COLS:  n_cols  = val[imm_pkg::N_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
        case (idx)
            imm_pkg::REG_M_ROWS:  return 32'(m_rows);
            imm_pkg::REG_K_DEPTH: return 32'(k_depth);
            imm_pkg::REG_N_COLS:  return 32'(n_cols);
            default:              return '0;
        endcase
    endfunction

    // True when the next activation only touches weights that were written.
    function bit act_safe();
        int unsigned k, n, j;
        k = depth_eff();
        n = cols_eff();
        for (j = 0; j < n; j++)
            if (!loaded[(j * k + k_pos) % STORE_SZ]) return 0;
        return 1;
    endfunction

    function void note_element(logic op, logic [imm_pkg::VAL_W-1:0] val);
        int unsigned k, n, lim, addr, idx, j;
        int          prod;
        bit          last_row;
        t_sum_beat   beat;
        k = depth_eff();
        n = cols_eff();
        if (op == imm_pkg::OP_WEIGHT) begin
            lim  = n * k;
            // a pointer left past the store size by a register change restarts at zero
            addr = (w_ptr < lim) ? w_ptr : 0;
            weights[addr % STORE_SZ] = val;
            loaded[addr % STORE_SZ]  = 1'b1;
            addr++;
            w_ptr = (addr >= lim) ? 0 : addr;
            k_pos = 0;
            foreach (acc[c]) acc[c] = '0;
            return;
        end
        for (j = 0; j < n; j++) begin
            idx  = (j * k + k_pos) % STORE_SZ;
            prod = int'($signed(val)) * int'($signed(weights[idx]));
            acc[j] = acc[j] + prod[imm_pkg::SUM_W-1:0];
        end
        if (k_pos + 1 < k) begin
            k_pos++;
            return;
        end
        last_row = (row_cnt + 1 >= rows_eff());
        for (j = 0; j < n; j++) begin
            beat.row        = row_cnt[imm_pkg::ROW_W-1:0];
            beat.col        = j[imm_pkg::COL_W-1:0];
            beat.sum        = acc[j];
            beat.row_end    = (j + 1 == n);
            beat.matrix_end = (j + 1 == n) && last_row;
            pending.push_back(beat);
        end
        foreach (acc[c]) acc[c] = '0;
        k_pos   = 0;
        row_cnt = last_row ? 0 : ((row_cnt + 1) & 32'hFFFF);
    endfunction

    function void check_beat(logic [imm_pkg::OUT_DW-1:0] data, logic row_end,
                             logic matrix_end);
        t_sum_beat got, want;
        got.row        = data[imm_pkg::ROW_W-1:0];
        got.col        = data[imm_pkg::ROW_W +: imm_pkg::COL_W];
        got.sum        = data[imm_pkg::ROW_W + imm_pkg::COL_W +: imm_pkg::SUM_W];
        got.row_end    = row_end;
        got.matrix_end = matrix_end;
        beats_seen++;
        if (pending.size() == 0) begin
            note_mismatch($sformatf("result with none pending: row %0d col %0d sum %0d",
                                    got.row, got.col, $signed(got.sum)));
            return;
        end
        want = pending.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.sum !== want.sum ||
            got.row_end !== want.row_end || got.matrix_end !== want.matrix_end)
            note_mismatch($sformatf(
                "exp row %0d col %0d sum %0d last %b end %b, got row %0d col %0d sum %0d last %b end %b",
                want.row, want.col, $signed(want.sum), want.row_end, want.matrix_end,
                got.row, got.col, $signed(got.sum), got.row_end, got.matrix_end));
    endfunction
endclass

module tb_int8_matmul_engine;
    import imm_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int QUIET_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 280;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [VAL_W-1:0]    i_s_axis_tdata  = '0;   // [7:0] value
    logic                i_s_axis_tuser  = 1'b0; // [0] opcode
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // [15:0] row_index, [19:16] col_index, [43:20] sum, [47:44] zero
    logic [OUT_DW-1:0]   o_m_axis_tdata;
    logic                o_m_axis_tlast;         // last_of_row
    logic                o_m_axis_tuser;         // [0] last_of_matrix
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [APB_AW-1:0]   paddr           = '0;
    logic [APB_DW-1:0]   pwdata          = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    column_sum_tracker col_sums = new;
    bit steady        = 1'b0;
    bit hold_off_go   = 1'b0;
    bit hold_off_done = 1'b0;
    int in_beats      = 0;
    int shapes        = 0;

    int8_matmul_engine u_dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    task automatic send_item(logic op, logic [VAL_W-1:0] val);
        if (!steady) begin
            while ($urandom_range(0, 99) < 27) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= val;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        col_sums.note_element(op, val);
        in_beats++;
    endtask

    // Wait for every pending result, then let an in-flight activation finish.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (col_sums.pending.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        col_sums.set_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_readback(logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== col_sums.reg_value(idx))
            col_sums.note_mismatch($sformatf("register %0d exp %0h got %0h",
                                             idx, col_sums.reg_value(idx), prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Junk above each field width checks that the register keeps only its own bits.
    task automatic set_shape(int unsigned m, int unsigned k, int unsigned n);
        apb_write(REG_M_ROWS,  ($urandom << M_W) | m);
        apb_write(REG_K_DEPTH, ($urandom << K_W) | k);
        apb_write(REG_N_COLS,  ($urandom << N_W) | n);
        apb_readback(REG_M_ROWS);
        apb_readback(REG_K_DEPTH);
        apb_readback(REG_N_COLS);
        shapes++;
    endtask

    // n*k weights cover the whole active store whatever the pointer start.
    task automatic load_weights();
        repeat (col_sums.depth_eff() * col_sums.cols_eff())
            send_item(OP_WEIGHT, VAL_W'($urandom));
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 8'h80;
            1:       return 8'h7f;
            2:       return 8'h00;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                col_sums.check_beat(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
            if (hold_off_go && !hold_off_done) begin
                hold          = HOLD_CYCLES;
                hold_off_done = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("int8_matmul_engine test failed");
        $finish;
    end

    initial begin : stimulus
        int          setting, stop_at, r;
        int unsigned m, k, n, n_eff;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 2x2 weights at both value extremes, two rows closing a matrix
        set_shape(2, 2, 2);
        send_item(OP_WEIGHT, 8'h7f);
        send_item(OP_WEIGHT, 8'h80);
        send_item(OP_WEIGHT, 8'h80);
        send_item(OP_WEIGHT, 8'h7f);
        send_item(OP_ACT, 8'h80);
        send_item(OP_ACT, 8'h7f);
        send_item(OP_ACT, 8'h7f);
        send_item(OP_ACT, 8'h7f);
        // half a row, then depth shrinks to the current position
        send_item(OP_ACT, 8'h01);
        drain();
        set_shape(4, 1, 2);
        send_item(OP_ACT, 8'hff);
        send_item(OP_ACT, 8'h12);
        send_item(OP_ACT, 8'hee);
        // row counter now past the shortened matrix
        drain();
        set_shape(2, 1, 2);
        send_item(OP_ACT, 8'h55);
        // leave the weight pointer beyond a smaller store
        drain();
        set_shape(1, 2, 2);
        send_item(OP_WEIGHT, 8'h11);
        send_item(OP_WEIGHT, 8'h22);
        send_item(OP_WEIGHT, 8'h33);
        drain();
        set_shape(1, 1, 2);
        send_item(OP_WEIGHT, 8'h01);
        send_item(OP_ACT, 8'h02);
        // zero registers act as one
        drain();
        set_shape(0, 0, 0);
        send_item(OP_WEIGHT, 8'h03);
        send_item(OP_ACT, 8'h81);
        drain();

        stop_at = in_beats + RANDOM_ITEMS;
        for (setting = 0; in_beats < stop_at || setting < 4; setting++) begin
            r = $urandom_range(0, 9);
            n = (r == 0) ? 0 : (r == 1) ? $urandom_range(17, 31) : $urandom_range(1, 16);
            n_eff = (n == 0) ? 1 : ((n > COLS_MAX_DEF) ? COLS_MAX_DEF : n);
            k = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 48 / n_eff);
            // one-element rows during the hold-off so result beats back up
            if (setting == 1) k = 1;
            r = $urandom_range(0, 5);
            m = (r == 0) ? 0 : (r == 1) ? 16'hffff : $urandom_range(1, 4);
            set_shape(m, k, n);
            // without a reload, leftover pointer and position carry into the new shape
            if (setting == 1 || $urandom_range(0, 9) != 0) load_weights();
            if (setting == 1) hold_off_go = 1'b1;
            steady = (setting == 3);
            repeat ($urandom_range(25, 45)) begin
                if ($urandom_range(0, 99) < 12 || !col_sums.act_safe())
                    send_item(OP_WEIGHT, VAL_W'($urandom));
                else
                    send_item(OP_ACT, pick_value());
            end
            steady = 1'b0;
            drain();
        end

        $display("covered %0d input beats and %0d result beats over %0d register settings,",
                 in_beats, col_sums.beats_seen, shapes);
        $display("including a %0d-cycle receiver stall with the input backed up; %0d mismatches",
                 HOLD_CYCLES, col_sums.errors);
        if (col_sums.errors == 0 && col_sums.pending.size() == 0)
            $display("int8_matmul_engine test passed");
        else
            $display("int8_matmul_engine test failed");
        $finish;
    end
endmodule
